### design/kfso_pkg.sv
// Shared constants, word types and helpers of the scalar-observation Kalman filter.
package kfso_pkg;

    localparam int MAX_DIM   = 4;
    localparam int FRAC_BITS = 16;

    localparam logic [14:0] RESET_VARIANCE = 15'd1000;
    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_OBS  = 1'b1;

    localparam logic [1:0] MS_TRANS     = 2'd0;
    localparam logic [1:0] MS_STATE_NZ  = 2'd1;
    localparam logic [1:0] MS_OBS_ROW   = 2'd2;
    localparam logic [1:0] MS_OBS_NZ    = 2'd3;

    localparam logic CFG_ACTIVE_DIM = 1'b0;
    localparam logic CFG_INIT_VAR   = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [1:0]         matrix_select;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] obs_value;
        logic               series_start;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic signed [31:0] innovation;
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] state_element;
        logic signed [31:0] cov_element;
        logic               last_of_run;
        logic               variance_fault;
    } t_out_word;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > 56'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -56'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/kfso_in_if.sv
// Input channel of the Kalman filter: valid, ready and one input word.
interface kfso_in_if;
    logic               valid;
    logic               ready;
    kfso_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/kfso_out_if.sv
// Result channel of the Kalman filter: valid, ready and one result word.
interface kfso_out_if;
    logic                valid;
    logic                ready;
    kfso_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/kalman_filter_scalar_obs.sv
// Scalar-observation Kalman filter: one shared memory, a sequenced MAC pipeline and a divider.
//
//   channel  | dir | handshake        | word
//   i_in     | in  | valid / ready    | load coefficient or observation
//   o_out    | out | valid / ready    | one covariance element per word, d*d words
//   i_cfg_*  | in  | write enable     | active_dim (index 0), init_variance (index 1)
//
// An observation runs through the single MAC unit and the one-bit-per-cycle divider,
// which computes the gain division. After reset, and on series start, the first
// observation first sweeps covariance and state. A stalled result holds the sequencer
// only in the output phase; the input is taken again once the last word sits in the
// register.
module kalman_filter_scalar_obs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [14:0]       i_cfg_data,
    kfso_in_if.sink           i_in,
    kfso_out_if.source        o_out
);
    localparam int N     = kfso_pkg::MAX_DIM;
    localparam int N2    = N * N;
    localparam int DEPTH = 5 * N2 + 6 * N + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(N + 2);

    localparam logic [AW-1:0] B_T  = AW'(0);
    localparam logic [AW-1:0] B_Q  = AW'(N2);
    localparam logic [AW-1:0] B_P  = AW'(2 * N2);
    localparam logic [AW-1:0] B_TP = AW'(3 * N2);
    localparam logic [AW-1:0] B_PP = AW'(4 * N2);
    localparam logic [AW-1:0] B_Z  = AW'(5 * N2);
    localparam logic [AW-1:0] B_X  = AW'(5 * N2 + N);
    localparam logic [AW-1:0] B_XP = AW'(5 * N2 + 2 * N);
    localparam logic [AW-1:0] B_PZ = AW'(5 * N2 + 3 * N);
    localparam logic [AW-1:0] B_K  = AW'(5 * N2 + 4 * N);
    localparam logic [AW-1:0] B_KF = AW'(5 * N2 + 5 * N);
    localparam logic [AW-1:0] B_H  = AW'(5 * N2 + 6 * N);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_INITP = 4'd1;
    localparam logic [3:0] PH_INITX = 4'd2;
    localparam logic [3:0] PH_TP    = 4'd3;
    localparam logic [3:0] PH_PP    = 4'd4;
    localparam logic [3:0] PH_XP    = 4'd5;
    localparam logic [3:0] PH_PRED  = 4'd6;
    localparam logic [3:0] PH_PZ    = 4'd7;
    localparam logic [3:0] PH_FV    = 4'd8;
    localparam logic [3:0] PH_DIV   = 4'd9;
    localparam logic [3:0] PH_KF    = 4'd10;
    localparam logic [3:0] PH_XUPD  = 4'd11;
    localparam logic [3:0] PH_PUPD  = 4'd12;
    localparam logic [3:0] PH_ORD   = 4'd13;
    localparam logic [3:0] PH_OLD   = 4'd14;
    localparam logic [3:0] PH_DRAIN = 4'd15;

    localparam logic [1:0] BS_MEM   = 2'd0;
    localparam logic [1:0] BS_ONE   = 2'd1;
    localparam logic [1:0] BS_FV    = 2'd2;
    localparam logic [1:0] BS_INNOV = 2'd3;

    localparam logic [1:0] DK_MEM  = 2'd0;
    localparam logic [1:0] DK_PRED = 2'd1;
    localparam logic [1:0] DK_FV   = 2'd2;

    localparam logic [1:0] DV_ISSUE = 2'd0;
    localparam logic [1:0] DV_LOAD  = 2'd1;
    localparam logic [1:0] DV_RUN   = 2'd2;

    function automatic logic [AW-1:0] ix2(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(N) + AW'(c));
    endfunction

    // shared memory with two registered read ports
    logic [31:0]        r_mem [DEPTH];
    logic signed [31:0] r_rda, r_rdb;
    logic [AW-1:0]      addr_a, addr_b;
    logic               n_we;
    logic [AW-1:0]      n_wa;
    logic [31:0]        n_wd;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        r_rda <= r_mem[addr_a];
        r_rdb <= r_mem[addr_b];
    end

    // control
    logic [3:0]         r_ph, r_next;
    logic [CW-1:0]      r_i, r_j, r_t, r_d;
    logic               r_fresh;
    logic [3:0]         r_active_dim;
    logic [14:0]        r_init_var;
    logic               r_ovalid;
    logic               r_s1_v, r_s2_v;
    logic [1:0]         r_dsub;
    logic [5:0]         r_dcnt;

    // payload
    logic [14:0]        r_diag;
    logic signed [31:0] r_obs, r_pred, r_innov, r_fv;
    logic               r_fault;
    logic [1:0]         r_s1_bsel, r_s1_dk, r_s2_dk;
    logic               r_s1_neg, r_s1_first, r_s1_last;
    logic               r_s2_neg, r_s2_first, r_s2_last;
    logic [AW-1:0]      r_s1_dst, r_s2_dst;
    logic signed [63:0] r_prod;
    logic signed [55:0] r_acc;
    logic [47:0]        r_dq;
    logic [32:0]        r_rem;
    logic               r_dneg;
    kfso_pkg::t_out_word r_out;

    // loop limits and term addressing per phase
    logic [CW-1:0] ni, nj, nt, kb;
    logic [1:0]    bsel, dk;
    logic          neg, issue;
    logic [AW-1:0] dst;

    always_comb begin
        ni = CW'(1);
        nj = CW'(1);
        nt = CW'(1);
        kb = r_t - CW'(1);
        addr_a = '0;
        addr_b = '0;
        bsel = BS_MEM;
        dk = DK_MEM;
        neg = 1'b0;
        issue = 1'b1;
        dst = '0;
        case (r_ph)
            PH_INITP: begin
                ni = CW'(N);
                nj = CW'(N);
                issue = 1'b0;
            end
            PH_INITX: begin
                ni = CW'(N);
                issue = 1'b0;
            end
            PH_TP: begin
                ni = r_d; nj = r_d; nt = r_d;
                addr_a = B_T + ix2(r_i, r_t);
                addr_b = B_P + ix2(r_t, r_j);
                dst = B_TP + ix2(r_i, r_j);
            end
            PH_PP: begin
                ni = r_d; nj = r_d; nt = r_d + CW'(1);
                if (r_t == '0) begin
                    addr_a = B_Q + ix2(r_i, r_j);
                    bsel = BS_ONE;
                end else begin
                    addr_a = B_TP + ix2(r_i, kb);
                    addr_b = B_T + ix2(r_j, kb);
                end
                dst = B_PP + ix2(r_i, r_j);
            end
            PH_XP: begin
                ni = r_d; nt = r_d;
                addr_a = B_T + ix2(r_i, r_t);
                addr_b = B_X + AW'(r_t);
                dst = B_XP + AW'(r_i);
            end
            PH_PRED: begin
                nt = r_d;
                addr_a = B_Z + AW'(r_t);
                addr_b = B_XP + AW'(r_t);
                dk = DK_PRED;
            end
            PH_PZ: begin
                ni = r_d; nt = r_d;
                addr_a = B_PP + ix2(r_i, r_t);
                addr_b = B_Z + AW'(r_t);
                dst = B_PZ + AW'(r_i);
            end
            PH_FV: begin
                nt = r_d + CW'(1);
                if (r_t == '0) begin
                    addr_a = B_H;
                    bsel = BS_ONE;
                end else begin
                    addr_a = B_Z + AW'(kb);
                    addr_b = B_PZ + AW'(kb);
                end
                dk = DK_FV;
            end
            PH_DIV: begin
                ni = r_d;
                issue = 1'b0;
                addr_a = B_PZ + AW'(r_i);
            end
            PH_KF: begin
                ni = r_d;
                addr_a = B_K + AW'(r_i);
                bsel = BS_FV;
                dst = B_KF + AW'(r_i);
            end
            PH_XUPD: begin
                ni = r_d; nt = CW'(2);
                if (r_t == '0) begin
                    addr_a = B_XP + AW'(r_i);
                    bsel = BS_ONE;
                end else begin
                    addr_a = B_K + AW'(r_i);
                    bsel = BS_INNOV;
                end
                dst = B_X + AW'(r_i);
            end
            PH_PUPD: begin
                ni = r_d; nj = r_d; nt = CW'(2);
                if (r_t == '0) begin
                    addr_a = B_PP + ix2(r_i, r_j);
                    bsel = BS_ONE;
                end else begin
                    addr_a = B_KF + AW'(r_i);
                    addr_b = B_K + AW'(r_j);
                    neg = 1'b1;
                end
                dst = B_P + ix2(r_i, r_j);
            end
            PH_ORD, PH_OLD: begin
                ni = r_d; nj = r_d;
                issue = 1'b0;
                addr_a = B_X + AW'(r_i);
                addr_b = B_P + ix2(r_i, r_j);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    logic is_mac;
    assign is_mac = issue && (r_ph != PH_IDLE) && (r_ph != PH_DRAIN);

    logic last_t, last_j, last_i;
    assign last_t = (r_t == nt - CW'(1));
    assign last_j = (r_j == nj - CW'(1));
    assign last_i = (r_i == ni - CW'(1));

    logic accept, out_take, out_load;
    assign i_in.ready = (r_ph == PH_IDLE);
    assign accept     = i_in.valid && (r_ph == PH_IDLE);
    assign out_take   = r_ovalid && o_out.ready;
    assign out_load   = (r_ph == PH_OLD) && (!r_ovalid || o_out.ready);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    logic step_en;
    assign step_en = is_mac || (r_ph == PH_INITP) || (r_ph == PH_INITX) || out_load;

    // accumulate stage
    logic signed [63:0] rnd;
    logic signed [55:0] termx, total, innov_diff;
    logic signed [31:0] tot_sat;
    assign rnd        = r_prod + 64'sd32768;
    assign termx      = {{8{rnd[63]}}, rnd[63:16]};
    assign total      = (r_s2_first ? 56'sd0 : r_acc) + (r_s2_neg ? -termx : termx);
    assign tot_sat    = kfso_pkg::sat32(total);
    assign innov_diff = {{24{r_obs[31]}}, r_obs} - {{24{tot_sat[31]}}, tot_sat};

    // operand B select at the multiply stage
    logic signed [31:0] opb;
    always_comb begin
        case (r_s1_bsel)
            BS_ONE:   opb = kfso_pkg::Q_ONE;
            BS_FV:    opb = r_fv;
            BS_INNOV: opb = r_innov;
            default:  opb = r_rdb;
        endcase
    end

    // divider step
    logic [32:0]        rem2, rem_sub;
    logic               ge;
    logic [47:0]        qf;
    logic signed [31:0] gain_q;
    logic signed [47:0] num_sh, mag;
    assign rem2    = {r_rem[31:0], r_dq[47]};
    assign rem_sub = rem2 - {1'b0, r_fv};
    assign ge      = (rem2 >= {1'b0, r_fv});
    assign qf      = {r_dq[46:0], ge};
    assign num_sh  = {r_rda, 16'b0};
    assign mag     = r_rda[31] ? -num_sh : num_sh;

    always_comb begin
        if (r_dneg) begin
            gain_q = (qf > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(qf[31:0]);
        end else begin
            gain_q = (qf > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf[31:0]);
        end
    end

    // single write port
    logic load_hit;
    always_comb begin
        n_we = 1'b0;
        n_wa = '0;
        n_wd = i_in.data.coef_value;
        load_hit = 1'b0;
        if (accept && i_in.data.operation == kfso_pkg::OP_LOAD) begin
            case (i_in.data.matrix_select)
                kfso_pkg::MS_TRANS: begin
                    load_hit = (4'(i_in.data.row_index) < 4'(N))
                            && (4'(i_in.data.col_index) < 4'(N));
                    n_wa = B_T + AW'(AW'(i_in.data.row_index) * AW'(N)
                                     + AW'(i_in.data.col_index));
                end
                kfso_pkg::MS_STATE_NZ: begin
                    load_hit = (4'(i_in.data.row_index) < 4'(N))
                            && (4'(i_in.data.col_index) < 4'(N));
                    n_wa = B_Q + AW'(AW'(i_in.data.row_index) * AW'(N)
                                     + AW'(i_in.data.col_index));
                end
                kfso_pkg::MS_OBS_ROW: begin
                    load_hit = (4'(i_in.data.col_index) < 4'(N));
                    n_wa = B_Z + AW'(i_in.data.col_index);
                end
                default: begin
                    load_hit = 1'b1;
                    n_wa = B_H;
                end
            endcase
            n_we = load_hit;
        end else if (r_ph == PH_INITP) begin
            n_we = 1'b1;
            n_wa = B_P + ix2(r_i, r_j);
            n_wd = (r_i == r_j) ? {1'b0, r_diag, 16'b0} : 32'd0;
        end else if (r_ph == PH_INITX) begin
            n_we = 1'b1;
            n_wa = B_X + AW'(r_i);
            n_wd = 32'd0;
        end else if (r_s2_v && r_s2_last && r_s2_dk == DK_MEM) begin
            n_we = 1'b1;
            n_wa = r_s2_dst;
            n_wd = tot_sat;
        end else if (r_ph == PH_DIV) begin
            n_wa = B_K + AW'(r_i);
            if (r_dsub == DV_LOAD && r_fault) begin
                n_we = 1'b1;
                n_wd = 32'd0;
            end else if (r_dsub == DV_RUN && r_dcnt == '0) begin
                n_we = 1'b1;
                n_wd = gain_q;
            end
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
            r_next <= PH_IDLE;
            r_i <= '0;
            r_j <= '0;
            r_t <= '0;
            r_d <= CW'(1);
            r_fresh <= 1'b1;
            r_active_dim <= 4'd4;
            r_init_var <= kfso_pkg::RESET_VARIANCE;
            r_ovalid <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_dsub <= DV_ISSUE;
            r_dcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == kfso_pkg::CFG_ACTIVE_DIM) begin
                    r_active_dim <= i_cfg_data[3:0];
                end else begin
                    r_init_var <= i_cfg_data;
                end
            end

            r_s1_v <= is_mac;
            r_s2_v <= r_s1_v;

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end

            if (step_en) begin
                if (!last_t) begin
                    r_t <= r_t + CW'(1);
                end else begin
                    r_t <= '0;
                    if (!last_j) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_j <= '0;
                        if (!last_i) begin
                            r_i <= r_i + CW'(1);
                        end else begin
                            r_i <= '0;
                        end
                    end
                end
            end

            case (r_ph)
                PH_IDLE: begin
                    if (accept && i_in.data.operation == kfso_pkg::OP_OBS) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_t <= '0;
                        if (r_active_dim == 4'd0) begin
                            r_d <= CW'(1);
                        end else if (r_active_dim > 4'(N)) begin
                            r_d <= CW'(N);
                        end else begin
                            r_d <= CW'(r_active_dim);
                        end
                        if (i_in.data.series_start || r_fresh) begin
                            r_ph <= PH_INITP;
                            r_fresh <= 1'b0;
                        end else begin
                            r_ph <= PH_TP;
                        end
                    end
                end
                PH_INITP: begin
                    if (last_j && last_i) r_ph <= PH_INITX;
                end
                PH_INITX: begin
                    if (last_i) r_ph <= PH_TP;
                end
                PH_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) r_ph <= r_next;
                end
                PH_DIV: begin
                    case (r_dsub)
                        DV_ISSUE: r_dsub <= DV_LOAD;
                        DV_LOAD: begin
                            if (r_fault) begin
                                r_dsub <= DV_ISSUE;
                                if (last_i) begin
                                    r_i <= '0;
                                    r_ph <= PH_KF;
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end else begin
                                r_dsub <= DV_RUN;
                                r_dcnt <= 6'd47;
                            end
                        end
                        default: begin
                            r_dcnt <= r_dcnt - 6'd1;
                            if (r_dcnt == '0) begin
                                r_dsub <= DV_ISSUE;
                                if (last_i) begin
                                    r_i <= '0;
                                    r_ph <= PH_KF;
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end
                        end
                    endcase
                end
                PH_ORD: r_ph <= PH_OLD;
                PH_OLD: begin
                    if (out_load) begin
                        r_ph <= (last_j && last_i) ? PH_IDLE : PH_ORD;
                    end
                end
                default: begin
                    // MAC phases: after the final term, drain the pipeline
                    if (last_t && last_j && last_i) begin
                        r_ph <= PH_DRAIN;
                        case (r_ph)
                            PH_TP:   r_next <= PH_PP;
                            PH_PP:   r_next <= PH_XP;
                            PH_XP:   r_next <= PH_PRED;
                            PH_PRED: r_next <= PH_PZ;
                            PH_PZ:   r_next <= PH_FV;
                            PH_FV:   r_next <= PH_DIV;
                            PH_KF:   r_next <= PH_XUPD;
                            PH_XUPD: r_next <= PH_PUPD;
                            default: r_next <= PH_ORD;
                        endcase
                    end
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_obs <= i_in.data.obs_value;
            r_diag <= i_in.data.series_start ? r_init_var : kfso_pkg::RESET_VARIANCE;
        end

        r_s1_bsel <= bsel;
        r_s1_dk <= dk;
        r_s1_neg <= neg;
        r_s1_first <= (r_t == '0);
        r_s1_last <= last_t;
        r_s1_dst <= dst;

        r_s2_dk <= r_s1_dk;
        r_s2_neg <= r_s1_neg;
        r_s2_first <= r_s1_first;
        r_s2_last <= r_s1_last;
        r_s2_dst <= r_s1_dst;
        r_prod <= r_rda * opb;

        if (r_s2_v) begin
            r_acc <= total;
            if (r_s2_last && r_s2_dk == DK_PRED) begin
                r_pred <= tot_sat;
                r_innov <= kfso_pkg::sat32(innov_diff);
            end
            if (r_s2_last && r_s2_dk == DK_FV) begin
                r_fv <= tot_sat;
                r_fault <= tot_sat[31] || (tot_sat == 32'sd0);
            end
        end

        if (r_ph == PH_DIV) begin
            if (r_dsub == DV_LOAD) begin
                r_dneg <= r_rda[31];
                r_rem <= '0;
                r_dq <= mag + 48'(r_fv[31:1]);
            end else if (r_dsub == DV_RUN) begin
                r_rem <= ge ? rem_sub : rem2;
                r_dq <= qf;
            end
        end

        if (out_load) begin
            r_out.prediction <= r_pred;
            r_out.innovation <= r_innov;
            r_out.out_row <= 3'(r_i);
            r_out.out_col <= 3'(r_j);
            r_out.state_element <= r_rda;
            r_out.cov_element <= r_rdb;
            r_out.last_of_run <= last_j && last_i;
            r_out.variance_fault <= r_fault;
        end
    end

endmodule

### tb/sv/kalman_filter_scalar_obs_tb.sv
`timescale 1ns / 100ps
// Testbench of the scalar-observation Kalman filter: directed table, random traffic, predictor.
module kalman_filter_scalar_obs_tb;
    import kfso_pkg::*;

    localparam int N_RANDOM   = 430;
    localparam int CYCLE_CAP  = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_ACTIVE_DIM;
    logic [14:0] i_cfg_data = '0;

    kfso_in_if  in_ch ();
    kfso_out_if out_ch ();

    kalman_filter_scalar_obs dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // filter model state
    logic [3:0]         mdl_dim;
    logic [14:0]        mdl_var;
    logic signed [31:0] mdl_t  [MAX_DIM*MAX_DIM];
    logic signed [31:0] mdl_q  [MAX_DIM*MAX_DIM];
    logic signed [31:0] mdl_z  [MAX_DIM];
    logic signed [31:0] mdl_h;
    logic signed [31:0] mdl_x  [MAX_DIM];
    logic signed [31:0] mdl_p  [MAX_DIM*MAX_DIM];

    t_out_word   pending_words[$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          faults_seen = 0;
    longint      cycle_count = 0;
    logic        fixed_valid;
    t_out_word   fixed_word;

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // rounded Q15.16 product: add half, floor
    function automatic longint qprod(input logic signed [31:0] a, input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] qquot(input logic signed [31:0] num,
                                                 input logic signed [31:0] den);
        longint n, mag, q;
        n   = longint'(num) * 65536;
        mag = (n < 0) ? -n : n;
        q   = (mag + longint'(den) / 2) / longint'(den);
        return clip((n < 0) ? -q : q);
    endfunction

    task automatic restart_series();
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++) mdl_p[i] = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            mdl_x[i] = '0;
            mdl_p[i*MAX_DIM+i] = clip(longint'(mdl_var) <<< FRAC_BITS);
        end
    endtask

    task automatic model_reset();
        mdl_dim = 4'd4;
        mdl_var = RESET_VARIANCE;
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
            mdl_t[i] = '0;
            mdl_q[i] = '0;
        end
        for (int i = 0; i < MAX_DIM; i++) mdl_z[i] = '0;
        mdl_h = '0;
        restart_series();
    endtask

    // run one word through the filter model, queue the covariance words it causes
    task automatic filter_step(input t_in_word w);
        logic signed [31:0] tp[MAX_DIM*MAX_DIM], pp[MAX_DIM*MAX_DIM];
        logic signed [31:0] xp[MAX_DIM], pz[MAX_DIM], k[MAX_DIM], kf[MAX_DIM];
        logic signed [31:0] pred, innov, fv;
        longint acc;
        logic fault;
        int d;
        t_out_word o;
        if (w.operation == OP_LOAD) begin
            case (w.matrix_select)
                MS_OBS_NZ: mdl_h = w.coef_value;
                MS_OBS_ROW: if (w.col_index < MAX_DIM) mdl_z[w.col_index] = w.coef_value;
                MS_TRANS: if (w.row_index < MAX_DIM && w.col_index < MAX_DIM)
                    mdl_t[w.row_index*MAX_DIM+w.col_index] = w.coef_value;
                default: if (w.row_index < MAX_DIM && w.col_index < MAX_DIM)
                    mdl_q[w.row_index*MAX_DIM+w.col_index] = w.coef_value;
            endcase
            return;
        end
        d = (mdl_dim < 1) ? 1 : ((mdl_dim > MAX_DIM) ? MAX_DIM : int'(mdl_dim));
        if (w.series_start) restart_series();
        for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++) begin
                acc = 0;
                for (int m = 0; m < d; m++) acc += qprod(mdl_t[i*MAX_DIM+m], mdl_p[m*MAX_DIM+j]);
                tp[i*MAX_DIM+j] = clip(acc);
            end
        for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++) begin
                acc = longint'(mdl_q[i*MAX_DIM+j]);
                for (int m = 0; m < d; m++) acc += qprod(tp[i*MAX_DIM+m], mdl_t[j*MAX_DIM+m]);
                pp[i*MAX_DIM+j] = clip(acc);
            end
        for (int i = 0; i < d; i++) begin
            acc = 0;
            for (int m = 0; m < d; m++) acc += qprod(mdl_t[i*MAX_DIM+m], mdl_x[m]);
            xp[i] = clip(acc);
        end
        acc = 0;
        for (int m = 0; m < d; m++) acc += qprod(mdl_z[m], xp[m]);
        pred  = clip(acc);
        innov = clip(longint'(w.obs_value) - longint'(pred));
        for (int i = 0; i < d; i++) begin
            acc = 0;
            for (int m = 0; m < d; m++) acc += qprod(pp[i*MAX_DIM+m], mdl_z[m]);
            pz[i] = clip(acc);
        end
        acc = longint'(mdl_h);
        for (int i = 0; i < d; i++) acc += qprod(mdl_z[i], pz[i]);
        fv = clip(acc);
        fault = (fv <= 0);
        for (int i = 0; i < d; i++) begin
            k[i]  = fault ? 32'sd0 : qquot(pz[i], fv);
            kf[i] = clip(qprod(k[i], fv));
        end
        for (int i = 0; i < d; i++) begin
            mdl_x[i] = clip(longint'(xp[i]) + qprod(k[i], innov));
            for (int j = 0; j < d; j++)
                mdl_p[i*MAX_DIM+j] = clip(longint'(pp[i*MAX_DIM+j]) - qprod(kf[i], k[j]));
        end
        for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++) begin
                o.prediction     = pred;
                o.innovation     = innov;
                o.out_row        = i[2:0];
                o.out_col        = j[2:0];
                o.state_element  = mdl_x[i];
                o.cov_element    = mdl_p[i*MAX_DIM+j];
                o.last_of_run    = (i == d-1 && j == d-1);
                o.variance_fault = fault;
                pending_words.push_back(o);
            end
    endtask

    // receiver: stall pattern of its own
    logic [6:0] stall_phase = '0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 7'd1;
        if (stall_phase[6]) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end
    initial out_ch.ready = 1'b0;

    // result check
    always @(posedge i_clk) begin
        t_out_word got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            words_seen <= words_seen + 1;
            if (got.variance_fault) faults_seen <= faults_seen + 1;
            if (fixed_valid) begin
                want = fixed_word;
                fixed_valid = 1'b0;
                void'(pending_words.pop_front());
            end else if (pending_words.size() == 0) begin
                want = got;
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = pending_words.pop_front();
            end
            if (got !== want) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("word mismatch: row %0d col %0d exp %h got %h",
                             want.out_row, want.out_col, want, got);
            end
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("kalman_filter_scalar_obs: mismatch");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        filter_step(w);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_ACTIVE_DIM) mdl_dim = v[3:0];
        else mdl_var = v;
    endtask

    function automatic t_in_word load_word(input logic [1:0] sel, input int r, input int c,
                                           input logic signed [31:0] v);
        t_in_word w;
        w = '0;
        w.operation     = OP_LOAD;
        w.matrix_select = sel;
        w.row_index     = r[2:0];
        w.col_index     = c[2:0];
        w.coef_value    = v;
        w.obs_value     = $urandom;
        w.series_start  = $urandom_range(0, 1);
        return w;
    endfunction

    function automatic t_in_word obs_word(input logic signed [31:0] y, input logic start);
        t_in_word w;
        w = '0;
        w.operation    = OP_OBS;
        w.matrix_select = $urandom_range(0, 3);
        w.row_index    = $urandom_range(0, 7);
        w.col_index    = $urandom_range(0, 7);
        w.coef_value   = $urandom;
        w.obs_value    = y;
        w.series_start = start;
        return w;
    endfunction

    // small coefficient, mostly near unity, now and then full range
    function automatic logic signed [31:0] rand_coef();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return $signed($urandom_range(0, 262143)) - 32'sd131072;
    endfunction

    // load every coefficient at the built size so nothing is read unwritten
    task automatic load_all(input logic diag_only);
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++) begin
                send_word(load_word(MS_TRANS, r, c,
                    diag_only ? ((r == c) ? Q_ONE : 32'sd0) : rand_coef()));
                send_word(load_word(MS_STATE_NZ, r, c,
                    diag_only ? ((r == c) ? Q_ONE : 32'sd0) : rand_coef()));
            end
        for (int c = 0; c < MAX_DIM; c++)
            send_word(load_word(MS_OBS_ROW, $urandom_range(0, 7), c,
                diag_only ? ((c == 0) ? Q_ONE : 32'sd0) : rand_coef()));
        send_word(load_word(MS_OBS_NZ, $urandom_range(0, 7), $urandom_range(0, 7),
            diag_only ? Q_ONE : $signed($urandom_range(0, 131072))));
    endtask

    typedef struct {
        t_in_word  word;
        logic      has_fixed;
        t_out_word fixed;
    } t_row;

    t_row directed_rows[$];

    initial begin
        t_row row;
        int burst;
        int n_obs;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        fixed_valid = 1'b0;
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity model, dimension 1 so outputs are readable
        write_reg(CFG_ACTIVE_DIM, 15'd0);
        load_all(1'b1);
        // ignored loads outside the built size
        row.has_fixed = 1'b0;
        row.word = load_word(MS_TRANS, 7, 0, 32'sh7FFF_FFFF);   directed_rows.push_back(row);
        row.word = load_word(MS_STATE_NZ, 0, 7, 32'sh8000_0000); directed_rows.push_back(row);
        row.word = load_word(MS_OBS_ROW, 0, 5, 32'sh8000_0000);  directed_rows.push_back(row);
        // P'=1001, F=1002; state and cov checked by predictor
        row.word = obs_word(32'sh0001_0000, 1'b1);                directed_rows.push_back(row);
        row.word = obs_word(32'sh7FFF_FFFF, 1'b0);                directed_rows.push_back(row);
        row.word = obs_word(32'sh8000_0000, 1'b0);                directed_rows.push_back(row);
        // negative observation noise drives F non-positive: fault
        row.word = load_word(MS_OBS_NZ, 0, 0, 32'sh8000_0000);   directed_rows.push_back(row);
        row.word = obs_word(32'sd0, 1'b1);
        row.has_fixed = 1'b1;
        row.fixed = '{prediction: 32'sd0, innovation: 32'sd0, out_row: 3'd0, out_col: 3'd0,
                      state_element: 32'sd0, cov_element: 32'sh03E9_0000,
                      last_of_run: 1'b1, variance_fault: 1'b1};
        directed_rows.push_back(row);
        foreach (directed_rows[n]) begin
            send_word(directed_rows[n].word);
            if (directed_rows[n].has_fixed) begin
                fixed_word  = directed_rows[n].fixed;
                fixed_valid = 1'b1;
            end
        end
        drop_valid();
        wait_drained();

        // random phases across register settings, extremes included
        n_obs = 0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(CFG_ACTIVE_DIM, 15'd4);  write_reg(CFG_INIT_VAR, 15'd32767); end
                1: begin write_reg(CFG_ACTIVE_DIM, 15'd15); write_reg(CFG_INIT_VAR, 15'd0); end
                2: begin write_reg(CFG_ACTIVE_DIM, 15'd1);  write_reg(CFG_INIT_VAR, 15'd1); end
                default: begin
                    write_reg(CFG_ACTIVE_DIM, 15'($urandom_range(0, 15)));
                    write_reg(CFG_INIT_VAR, $urandom);
                end
            endcase
            load_all(1'b0);
            burst = 0;
            for (int n = 0; n < N_RANDOM / 8 - 20; n++) begin
                if (burst == 0) begin
                    drop_valid();
                    repeat ($urandom_range(0, 6)) @(posedge i_clk);
                    burst = $urandom_range(1, 12);
                end
                burst--;
                if ($urandom_range(0, 4) == 0) begin
                    send_word(load_word($urandom_range(0, 3), $urandom_range(0, 3),
                                        $urandom_range(0, 3), rand_coef()));
                end else begin
                    send_word(obs_word(($urandom_range(0, 9) == 0) ? $urandom
                        : $signed($urandom_range(0, 4194303)) - 32'sd2097152,
                        $urandom_range(0, 7) == 0));
                    n_obs++;
                end
            end
            drop_valid();
            wait_drained();
        end

        $display("covered %0d random observations over 8 register settings,", n_obs);
        $display("%0d words checked, %0d carrying the variance fault", words_seen, faults_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("kalman_filter_scalar_obs: match");
        end else begin
            $display("kalman_filter_scalar_obs: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
design/kfso_pkg.sv
design/kfso_in_if.sv
design/kfso_out_if.sv
design/kalman_filter_scalar_obs.sv
tb/sv/kalman_filter_scalar_obs_tb.sv
